// File: rtl/core/wall_follow_pid_drive_macros.svh
// Assertion macros shared by the wall-follow drive RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef WALL_FOLLOW_PID_DRIVE_MACROS_SVH
`define WALL_FOLLOW_PID_DRIVE_MACROS_SVH

`ifndef ASSERT_OFF
`define WFPD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define WFPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define WFPD_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define WFPD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/core/wfpd_pkg.sv
// Package for the wall-follow drive: constants, register indexes, stage type.
// No dependencies.
`default_nettype none

package wfpd_pkg;

    localparam int DIST_W     = 8;
    localparam int MOTOR_W    = 8;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 8;
    localparam int ERR_W      = 9;
    localparam int ISUM_W     = 10;
    localparam int NUM_W      = 18;
    localparam int MAG_W      = 17;
    localparam int QUO_W      = 15;
    localparam int DSUM_W     = 16;

    localparam logic [DIST_W-1:0] LEFT_FAR_LIMIT = 8'd50;
    localparam logic [DIST_W-1:0] CLOSE_FRONT    = 8'd20;
    localparam logic signed [ERR_W-1:0] FAR_ERROR = 9'sd5;
    localparam logic signed [NUM_W-1:0] KP_X10    = 18'sd80;
    localparam logic signed [NUM_W-1:0] KD_X10    = 18'sd300;
    localparam logic signed [ISUM_W-1:0] INT_LIMIT = 10'sd100;
    localparam logic signed [DSUM_W-1:0] MOTOR_LIMIT = 16'sd127;

    localparam logic [MAG_W-1:0] DIV10_MULT  = 17'd52429;
    localparam int               DIV10_SHIFT = 19;

    localparam logic signed [MOTOR_W-1:0] RST_BASE_SPEED  = 8'sd50;
    localparam logic [DIST_W-1:0]         RST_TARGET_DIST = 8'd35;
    localparam logic [DIST_W-1:0]         RST_STOP_DIST   = 8'd13;

    localparam logic [CFG_ADDR_W-1:0] REG_BASE_SPEED  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TARGET_DIST = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_STOP_DIST   = 2'd2;

    typedef struct packed {
        logic                    halt;
        logic                    zero;
        logic                    close;
        logic [DIST_W-1:0]       right;
        logic                    backoff;
        logic signed [NUM_W-1:0] num;
    } t_s1_info;

endpackage

`default_nettype wire

// File: rtl/core/wfpd_if.sv
// Handshake channels of the wall-follow drive: sensor input, motor output, config write.
// Depends on wfpd_pkg.
`default_nettype none

interface wfpd_in_if;
    import wfpd_pkg::*;
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] front_left;
    logic [DIST_W-1:0] front_right;
    logic              left_bump;
    logic              right_bump;
    modport source (output valid, front_left, front_right, left_bump, right_bump,
                    input ready);
    modport sink (input valid, front_left, front_right, left_bump, right_bump,
                  output ready);
endinterface

interface wfpd_out_if;
    import wfpd_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [MOTOR_W-1:0] left_motor;
    logic signed [MOTOR_W-1:0] right_motor;
    logic                      backoff;
    logic                      halted;
    modport source (output valid, left_motor, right_motor, backoff, halted,
                    input ready);
    modport sink (input valid, left_motor, right_motor, backoff, halted,
                  output ready);
endinterface

interface wfpd_cfg_if;
    import wfpd_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, addr, data, input ready);
    modport sink (input valid, addr, data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/wfpd_drive.sv
// Steering drive: numerator / 10 toward zero, plus base speed, saturated to +/-127.
// Depends on wfpd_pkg.
`default_nettype none

module wfpd_drive (
    input  logic signed [wfpd_pkg::NUM_W-1:0]   i_num,
    input  logic signed [wfpd_pkg::MOTOR_W-1:0] i_base,
    output logic signed [wfpd_pkg::MOTOR_W-1:0] o_drive
);
    import wfpd_pkg::*;

    logic                     neg;
    logic [MAG_W-1:0]         mag;
    logic [2*MAG_W-1:0]       prod;
    logic [QUO_W-1:0]         quo;
    logic signed [DSUM_W-1:0] quo_s;
    logic signed [DSUM_W-1:0] dsum;

    always_comb begin
        neg   = i_num[NUM_W-1];
        mag   = neg ? MAG_W'(-i_num) : MAG_W'(i_num);
        prod  = {{MAG_W{1'b0}}, mag} * {{MAG_W{1'b0}}, DIV10_MULT};
        quo   = prod[DIV10_SHIFT +: QUO_W];
        quo_s = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
        dsum  = quo_s + DSUM_W'(i_base);
        priority if (dsum > MOTOR_LIMIT) begin
            o_drive = MOTOR_W'(MOTOR_LIMIT);
        end else if (dsum < -MOTOR_LIMIT) begin
            o_drive = MOTOR_W'(-MOTOR_LIMIT);
        end else begin
            o_drive = dsum[MOTOR_W-1:0];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/wall_follow_pid_drive.sv
// Wall-follow PID drive: two-stage pipeline, error/rate/integral then divide and select.
// Results pass r_s1, then the output registers; one item per cycle unless o_out.ready stalls.
// Stage 1 updates the state and registers the PID numerator; stage 2 runs wfpd_drive.
// Synchronous active-low reset clears valids, state and the halt flag and loads the
// register defaults (base speed 50, target 35, stop 13).
// Depends on wfpd_pkg, wfpd_if, wfpd_drive and the macro header.
`default_nettype none

`include "wall_follow_pid_drive_macros.svh"

module wall_follow_pid_drive (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wfpd_in_if.sink     i_in,
    wfpd_out_if.source  o_out,
    wfpd_cfg_if.sink    i_cfg
);
    import wfpd_pkg::*;

    localparam logic signed [MOTOR_W-1:0] INT_HI = MOTOR_W'(INT_LIMIT);
    localparam logic signed [MOTOR_W-1:0] INT_LO = MOTOR_W'(-INT_LIMIT);

    logic signed [MOTOR_W-1:0] r_base_speed;
    logic [DIST_W-1:0]         r_target;
    logic [DIST_W-1:0]         r_stop;
    logic [DIST_W-1:0]         r_prev_left;
    logic signed [MOTOR_W-1:0] r_integral;
    logic                      r_stopped;
    logic                      r_s1_valid;
    t_s1_info                  r_s1;
    logic                      r_out_valid;
    logic signed [MOTOR_W-1:0] r_out_left;
    logic signed [MOTOR_W-1:0] r_out_right;
    logic                      r_out_backoff;
    logic                      r_out_halted;

    t_s1_info                  n_s1;
    logic signed [MOTOR_W-1:0] n_integral;
    logic signed [MOTOR_W-1:0] n_out_left;
    logic signed [MOTOR_W-1:0] n_out_right;

    logic                      in_xfer;
    logic                      out_adv;
    logic                      s1_adv;
    logic                      cfg_xfer;
    logic                      left_near;
    logic                      reach;
    logic signed [ERR_W-1:0]   err;
    logic signed [ERR_W-1:0]   rate;
    logic signed [ISUM_W-1:0]  isum;
    logic signed [NUM_W-1:0]   p_err;
    logic signed [NUM_W-1:0]   p_rate;
    logic signed [MOTOR_W-1:0] drive;

    assign out_adv     = !r_out_valid || o_out.ready;
    assign s1_adv      = !r_s1_valid || out_adv;
    assign i_in.ready  = s1_adv;
    assign in_xfer     = i_in.valid && s1_adv;
    assign i_cfg.ready = 1'b1;
    assign cfg_xfer    = i_cfg.valid;

    always_comb begin
        left_near = i_in.front_left <= LEFT_FAR_LIMIT;
        if (left_near) begin
            err  = $signed({1'b0, i_in.front_left}) - $signed({1'b0, r_target});
            rate = $signed({1'b0, i_in.front_left}) - $signed({1'b0, r_prev_left});
        end else begin
            err  = FAR_ERROR;
            rate = '0;
        end
        isum = ISUM_W'(r_integral) + ISUM_W'(err);
        if (isum > INT_LIMIT || isum < -INT_LIMIT) begin
            n_integral = '0;
        end else begin
            n_integral = isum[MOTOR_W-1:0];
        end
        p_err  = NUM_W'(err) * KP_X10;
        p_rate = NUM_W'(rate) * KD_X10;
        reach  = i_in.front_right <= r_stop;

        n_s1.right = i_in.front_right;
        n_s1.close = i_in.front_right < CLOSE_FRONT;
        n_s1.num   = p_err + p_rate + NUM_W'(n_integral);
        if (r_stopped) begin
            n_s1.halt    = 1'b1;
            n_s1.zero    = 1'b1;
            n_s1.backoff = 1'b0;
        end else begin
            n_s1.halt    = reach;
            n_s1.zero    = reach;
            n_s1.backoff = i_in.left_bump || i_in.right_bump;
        end
    end

    wfpd_drive u_drive (
        .i_num   (r_s1.num),
        .i_base  (r_base_speed),
        .o_drive (drive)
    );

    always_comb begin
        priority if (r_s1.zero) begin
            n_out_left  = '0;
            n_out_right = '0;
        end else if (r_s1.close) begin
            n_out_left  = $signed(r_s1.right);
            n_out_right = $signed(r_s1.right);
        end else begin
            n_out_left  = r_base_speed;
            n_out_right = drive;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_speed <= RST_BASE_SPEED;
            r_target     <= RST_TARGET_DIST;
            r_stop       <= RST_STOP_DIST;
        end else if (cfg_xfer) begin
            unique case (i_cfg.addr)
                REG_BASE_SPEED:  r_base_speed <= $signed(i_cfg.data);
                REG_TARGET_DIST: r_target     <= i_cfg.data;
                REG_STOP_DIST:   r_stop       <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_left <= '0;
            r_integral  <= '0;
            r_stopped   <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer && !r_stopped) begin
                r_prev_left <= i_in.front_left;
                r_integral  <= n_integral;
                r_stopped   <= reach;
            end
            if (s1_adv) begin
                r_s1_valid <= in_xfer;
            end
            if (out_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s1 <= n_s1;
        end
        if (out_adv) begin
            r_out_left    <= n_out_left;
            r_out_right   <= n_out_right;
            r_out_backoff <= r_s1.backoff;
            r_out_halted  <= r_s1.halt;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.left_motor  = r_out_left;
    assign o_out.right_motor = r_out_right;
    assign o_out.backoff     = r_out_backoff;
    assign o_out.halted      = r_out_halted;

    `WFPD_ASSERT_NEXT(a_halt_sticky, i_clk, i_rst_n, r_stopped, r_stopped)
    `WFPD_ASSERT_NEXT(a_halt_freezes_state, i_clk, i_rst_n, r_stopped,
        $stable(r_prev_left) && $stable(r_integral))
    `WFPD_ASSERT_IMPLY(a_integral_range, i_clk, i_rst_n, 1'b1,
        r_integral <= INT_HI && r_integral >= INT_LO)
    `WFPD_ASSERT_IMPLY(a_halt_zero_motors, i_clk, i_rst_n, r_out_valid && r_out_halted,
        r_out_left == '0 && r_out_right == '0)

endmodule

`default_nettype wire
